// File: rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is high
`define SLTW_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sltw assertion failed");

// next-cycle implication, masked while reset is high
`define SLTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sltw assertion failed");

// next-cycle implication that also holds across reset
`define SLTW_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sltw assertion failed");

`endif

// File: rtl/core/sltw_pkg.sv
`timescale 1ns / 1ps

package sltw_pkg;

   localparam int unsigned LCD_CELLS = 12;
   localparam int unsigned LINE_POSITIONS = 5;
   localparam int unsigned GLYPH_COUNT = 60;

   localparam logic KIND_PRINT = 1'b0;
   localparam logic KIND_TOGGLE = 1'b1;

   localparam logic [1:0] ALIGN_LEFT = 2'd0;
   localparam logic [1:0] ALIGN_CENTER = 2'd1;

   localparam logic [3:0] HEART_CELL = 4'd1;
   localparam logic [3:0] STOPWATCH_CELL = 4'd2;
   localparam logic [7:0] ICON_BIT = 8'h08;

   localparam logic [7:0] UPPER_MASK = 8'hF7;
   localparam logic [7:0] LOWER_MASK = 8'h7F;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_Z = 8'h5A;
   localparam logic [7:0] CHAR_BRACKET = 8'h5B;
   localparam logic [7:0] CASE_FOLD = 8'hDF;

   localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT] = '{
      8'h00, 8'h60, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h05, 8'h60, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00,
      8'hF5, 8'h60, 8'hB6, 8'hF2, 8'h63, 8'hD3, 8'hD7, 8'h70,
      8'hF7, 8'hF3, 8'h00, 8'h00, 8'h00, 8'h82, 8'h00, 8'h00,
      8'h00, 8'h77, 8'hC7, 8'h95, 8'hE6, 8'h97, 8'h17, 8'hF3,
      8'h67, 8'h05, 8'hF0, 8'h87, 8'h85, 8'h75, 8'h46, 8'hC6,
      8'h37, 8'hF5, 8'h06, 8'hD3, 8'h87, 8'hC4, 8'hC4, 8'h02,
      8'h67, 8'hE3, 8'hB6, 8'h00
   };

   typedef struct packed {
      logic       kind;
      logic       line_select;
      logic [1:0] align;
      logic       keep_line;
      logic [2:0] text_length;
      logic [7:0] char_a;
      logic [7:0] char_b;
      logic [7:0] char_c;
      logic [7:0] char_d;
      logic [7:0] char_e;
      logic       heart_icon;
   } req_word_type;

   // clamp to the font range, fold lower case, then look up the segments
   function automatic logic [7:0] glyph_of(input logic [7:0] code);
      logic [7:0] s;
      logic [7:0] offset;
      s = code;
      if (s < CHAR_SPACE) begin
         s = CHAR_SPACE;
      end
      if (s > CHAR_Z) begin
         s = s & CASE_FOLD;
         if (s > CHAR_BRACKET) begin
            s = CHAR_BRACKET;
         end
      end
      offset = s - CHAR_SPACE;
      return GLYPH_ROM[offset[5:0]];
   endfunction

   // display cell behind a line position; upper position 0 does not exist
   function automatic logic [3:0] cell_of(input logic line, input logic [2:0] pos);
      logic [3:0] cell_num;
      cell_num = 4'd0;
      if (line) begin
         case (pos)
            3'd0:    cell_num = 4'd11;
            3'd1:    cell_num = 4'd10;
            3'd2:    cell_num = 4'd9;
            3'd3:    cell_num = 4'd8;
            3'd4:    cell_num = 4'd7;
            default: cell_num = 4'd7;
         endcase
      end else begin
         case (pos)
            3'd0:    cell_num = 4'd0;
            3'd1:    cell_num = 4'd1;
            3'd2:    cell_num = 4'd2;
            3'd3:    cell_num = 4'd3;
            3'd4:    cell_num = 4'd5;
            default: cell_num = 4'd5;
         endcase
      end
      return cell_num;
   endfunction

endpackage

// File: rtl/core/sltw_if.sv
`timescale 1ns / 1ps

interface sltw_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic       line_select;
   logic [1:0] align;
   logic       keep_line;
   logic [2:0] text_length;
   logic [7:0] char_a;
   logic [7:0] char_b;
   logic [7:0] char_c;
   logic [7:0] char_d;
   logic [7:0] char_e;
   logic       heart_icon;

   modport source (
      output valid, kind, line_select, align, keep_line, text_length,
      output char_a, char_b, char_c, char_d, char_e, heart_icon,
      input  ready
   );
   modport sink (
      input  valid, kind, line_select, align, keep_line, text_length,
      input  char_a, char_b, char_c, char_d, char_e, heart_icon,
      output ready
   );
endinterface

interface sltw_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] cell_address;
   logic [7:0] cell_value;
   logic       last_cell;

   modport source (
      output valid, cell_address, cell_value, last_cell,
      input  ready
   );
   modport sink (
      input  valid, cell_address, cell_value, last_cell,
      output ready
   );
endinterface

// File: rtl/core/segment_lcd_text_writer.sv
`timescale 1ns / 1ps

// Segment LCD text writer: turns print and icon-toggle words into updates of
// a 12-byte segment display memory and reports every cell it changes.
// req: one word per print or toggle command, valid/ready handshake.
// rsp: one word per touched cell (address, new byte), last_cell marks the end
// of a command; a print touches up to five cells, a toggle exactly one.
// A command is held in the input register, then the encoder works out all
// new cell bytes combinationally, writes the display memory and loads a
// five-entry result buffer whose words then go out on rsp.
// The result buffer drains one word per cycle while rsp.ready is high, one
// word per touched cell; a keep with no text touches no cell and gives no
// word.
// The next command is encoded in the cycle the previous one's last word leaves.
// Reset clears the display memory and empties the input register and the
// result buffer.
// When rsp stalls, the buffer holds its word and the input register still
// takes one more command; req.ready then drops until the buffer frees.

module segment_lcd_text_writer #(
   parameter int unsigned DISPLAY_CELLS = sltw_pkg::LCD_CELLS
) (
   input logic        clock,
   input logic        reset,
   sltw_req_if.sink   req,
   sltw_rsp_if.source rsp
);

   localparam int unsigned Slots = sltw_pkg::LINE_POSITIONS;

   sltw_pkg::req_word_type hold_ff;
   logic                   hold_valid_ff;
   logic                   hold_valid_in;

   logic [7:0] mem_ff [DISPLAY_CELLS];
   logic [7:0] mem_in [DISPLAY_CELLS];

   logic [Slots-1:0] pend_ff;
   logic [Slots-1:0] pend_in;
   logic [3:0]       addr_ff [Slots];
   logic [7:0]       value_ff [Slots];

   logic [Slots-1:0] pend_low;
   logic [Slots-1:0] pend_rest;
   logic [2:0]       emit_idx;
   logic             buffer_free;
   logic             load;

   logic       line;
   logic [2:0] line_len;
   logic [2:0] len_c;
   logic [2:0] first;
   logic [2:0] start;
   logic [7:0] mask;
   logic [7:0] keep_bits;
   logic [3:0] tog_cell;
   logic [7:0] tog_value;

   logic [3:0]       pos_cell [Slots];
   logic [7:0]       pos_value [Slots];
   logic [Slots-1:0] pos_touched;
   logic [3:0]       load_addr [Slots];
   logic [7:0]       load_value [Slots];
   logic [Slots-1:0] load_mask;

   // result buffer bookkeeping
   assign pend_low = pend_ff & (~pend_ff + Slots'(1));
   assign pend_rest = pend_ff & ~pend_low;
   assign buffer_free = (pend_ff == '0) || ((pend_rest == '0) && rsp.ready);
   assign load = hold_valid_ff && buffer_free;
   assign req.ready = !hold_valid_ff || load;

   always_comb begin
      emit_idx = 3'd0;
      for (int k = Slots - 1; k >= 0; k--) begin
         if (pend_ff[k]) begin
            emit_idx = 3'(k);
         end
      end
   end

   assign rsp.valid = pend_ff != '0;
   assign rsp.cell_address = addr_ff[emit_idx];
   assign rsp.cell_value = value_ff[emit_idx];
   assign rsp.last_cell = pend_rest == '0;

   // line geometry and placement
   always_comb begin
      line = hold_ff.line_select;
      line_len = line ? 3'd5 : 3'd4;
      len_c = (hold_ff.text_length > line_len) ? line_len : hold_ff.text_length;
      first = {2'b00, !line};
      mask = line ? sltw_pkg::LOWER_MASK : sltw_pkg::UPPER_MASK;
      keep_bits = ~mask;
      case (hold_ff.align)
         sltw_pkg::ALIGN_LEFT:   start = first;
         sltw_pkg::ALIGN_CENTER: start = ((line_len - len_c) >> 1) + first;
         default:                start = 3'd5 - len_c;
      endcase
      tog_cell = hold_ff.heart_icon ? sltw_pkg::HEART_CELL : sltw_pkg::STOPWATCH_CELL;
      tog_value = mem_ff[tog_cell] ^ sltw_pkg::ICON_BIT;
   end

   // per line position: clear, write the glyph, or leave the cell alone
   always_comb begin
      logic [2:0] pos;
      logic [2:0] rel;
      logic       in_text;
      logic       cleared;
      logic [7:0] ch;
      logic [7:0] seg;
      logic [7:0] cur;
      for (int p = 0; p < Slots; p++) begin
         pos = 3'(p);
         rel = pos - start;
         in_text = (pos >= start) && (rel < len_c);
         cleared = !hold_ff.keep_line && (pos >= first);
         case (rel)
            3'd0:    ch = hold_ff.char_a;
            3'd1:    ch = hold_ff.char_b;
            3'd2:    ch = hold_ff.char_c;
            3'd3:    ch = hold_ff.char_d;
            3'd4:    ch = hold_ff.char_e;
            default: ch = hold_ff.char_a;
         endcase
         seg = sltw_pkg::glyph_of(ch);
         if (line) begin
            seg = {seg[3:0], seg[7:4]};
         end
         pos_cell[p] = sltw_pkg::cell_of(line, pos);
         cur = mem_ff[pos_cell[p]];
         if (in_text) begin
            pos_value[p] = (cur & keep_bits) | (seg & mask);
         end else if (cleared) begin
            pos_value[p] = cur & keep_bits;
         end else begin
            pos_value[p] = cur;
         end
         pos_touched[p] = in_text || cleared;
      end
   end

   // what goes into the result buffer and the display memory
   always_comb begin
      if (hold_ff.kind == sltw_pkg::KIND_TOGGLE) begin
         load_mask = Slots'(1);
         for (int p = 0; p < Slots; p++) begin
            load_addr[p] = tog_cell;
            load_value[p] = tog_value;
         end
      end else begin
         load_mask = pos_touched;
         for (int p = 0; p < Slots; p++) begin
            load_addr[p] = pos_cell[p];
            load_value[p] = pos_value[p];
         end
      end

      for (int c = 0; c < DISPLAY_CELLS; c++) begin
         mem_in[c] = mem_ff[c];
      end
      if (load) begin
         for (int p = 0; p < Slots; p++) begin
            if (load_mask[p]) begin
               mem_in[load_addr[p]] = load_value[p];
            end
         end
      end

      if (load) begin
         pend_in = load_mask;
      end else if (rsp.valid && rsp.ready) begin
         pend_in = pend_rest;
      end else begin
         pend_in = pend_ff;
      end

      if (req.valid && req.ready) begin
         hold_valid_in = 1'b1;
      end else if (load) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         pend_ff <= '0;
         for (int c = 0; c < DISPLAY_CELLS; c++) begin
            mem_ff[c] <= 8'h00;
         end
      end else begin
         hold_valid_ff <= hold_valid_in;
         pend_ff <= pend_in;
         for (int c = 0; c < DISPLAY_CELLS; c++) begin
            mem_ff[c] <= mem_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         hold_ff.kind <= req.kind;
         hold_ff.line_select <= req.line_select;
         hold_ff.align <= req.align;
         hold_ff.keep_line <= req.keep_line;
         hold_ff.text_length <= req.text_length;
         hold_ff.char_a <= req.char_a;
         hold_ff.char_b <= req.char_b;
         hold_ff.char_c <= req.char_c;
         hold_ff.char_d <= req.char_d;
         hold_ff.char_e <= req.char_e;
         hold_ff.heart_icon <= req.heart_icon;
      end
      if (load) begin
         for (int p = 0; p < Slots; p++) begin
            addr_ff[p] <= load_addr[p];
            value_ff[p] <= load_value[p];
         end
      end
   end

endmodule

// File: rtl/core/sltw_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sltw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_cell_address,
   input logic [7:0] rsp_cell_value,
   input logic       rsp_last_cell
);

   // a stalled word holds
   `SLTW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cell_address) && $stable(rsp_cell_value) && $stable(rsp_last_cell))

   // only real display cells are ever reported
   `SLTW_ASSERT(a_cell_known, clock, reset, rsp_valid, rsp_cell_address == 4'd1 || rsp_cell_address == 4'd2 || rsp_cell_address == 4'd3 || rsp_cell_address == 4'd5 || rsp_cell_address == 4'd7 || rsp_cell_address == 4'd8 || rsp_cell_address == 4'd9 || rsp_cell_address == 4'd10 || rsp_cell_address == 4'd11)

   // the rest of a command follows without a gap
   `SLTW_ASSERT_NEXT(a_cmd_continues, clock, reset, rsp_valid && rsp_ready && !rsp_last_cell, rsp_valid)

   // reset empties the buffer and opens the input
   `SLTW_ASSERT_ALWAYS_NEXT(a_reset_idle, clock, reset, !rsp_valid && req_ready)

endmodule

bind segment_lcd_text_writer sltw_checker u_sltw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_cell_address (rsp.cell_address),
   .rsp_cell_value   (rsp.cell_value),
   .rsp_last_cell    (rsp.last_cell)
);
